### hdl/dmxsr_pkg.sv
package dmxsr_pkg;

	typedef enum logic [1:0] {
		FUNC_WORD = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	localparam int unsigned IDX_W = 10;

	localparam logic [IDX_W-1:0] SLOT_LIMIT  = 10'd513;
	localparam logic [8:0]       CHANNEL_MAX = 9'd509;
	localparam logic [15:0]      TIMEOUT_RST = 16'd500;
	localparam logic [8:0]       DATA_FLAG   = 9'h100;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
	} wr_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] quo;
		logic [1:0]       rem;
	} div3_t;

	// Divide by three through the reciprocal 683/2048, exact below 2048.
	function automatic div3_t div3(input logic [IDX_W-1:0] x);
		logic [19:0]      prod;
		logic [IDX_W-1:0] three_q;
		div3_t            res;
		prod     = {10'd0, x} * 20'd683;
		res.quo  = {1'b0, prod[19:11]};
		three_q  = {res.quo[IDX_W-2:0], 1'b0} + res.quo;
		res.rem  = 2'(x - three_q);
		return res;
	endfunction

endpackage

### hdl/dmx512_slot_receiver.sv
// A read request passes the input register, then the memory read into the
// result register, which holds its levels.
// Throughput: one request per cycle of any kind; a read waits only when the
// result register is full and stalled. Slot bytes sit in three banks by index mod 3.
// Reset: control state clears at once; a fill count makes unwritten slots read
// as zero, so there is no clearing pass and requests are taken right after reset.
module dmx512_slot_receiver
	import dmxsr_pkg::*;
#(
	parameter int unsigned SLOT_STORE_DEPTH = 516
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [8:0]  rx_word,
	input  logic [8:0]  channel,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  level_a,
	output logic [7:0]  level_b,
	output logic [7:0]  level_c,
	output logic        signal_lost
);

	// configuration
	logic [15:0] timeout_q;

	// input register
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [8:0]  word_s1;
	logic [8:0]  chan_s1;

	// frame and timer state
	logic [IDX_W-1:0] slot_idx_q;
	logic             pending_q;
	logic [15:0]      countdown_q;
	logic             lost_q;

	// result register control
	logic        valid_s2;
	logic        lost_s2;

	logic             s2_free;
	logic             fire_s1;
	logic             is_read;
	logic             lost_next;
	logic [8:0]       chan_clamp;
	logic [IDX_W-1:0] rd_base;
	wr_req_t          wr;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && (paddr == REG_TIMEOUT)) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// Only a read needs room in the result register; line words and ticks
	// retire from the input register whatever the output side does.
	assign is_read  = (func_s1 == FUNC_READ);
	assign s2_free  = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && (!is_read || s2_free);
	assign in_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			word_s1 <= rx_word;
			chan_s1 <= channel;
		end
	end

	// Slot data: advance the index and write the byte at the new index.
	// The entry for the start code is never read back, so a break only
	// rewinds the index.
	always_comb begin
		wr      = '0;
		wr.idx  = slot_idx_q + 10'd1;
		wr.data = word_s1[7:0];
		wr.en   = fire_s1 && (func_s1 == FUNC_WORD) && ((word_s1 & DATA_FLAG) != 9'd0)
			&& (slot_idx_q <= SLOT_LIMIT);
	end

	// Lost flag as the read leaves it.
	always_comb begin
		priority if (pending_q) begin
			lost_next = 1'b0;
		end else if (countdown_q == 16'd0) begin
			lost_next = 1'b1;
		end else begin
			lost_next = lost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_idx_q  <= '0;
			pending_q   <= 1'b0;
			countdown_q <= TIMEOUT_RST;
			lost_q      <= 1'b1;
		end else if (fire_s1) begin
			unique case (func_s1)
				FUNC_WORD: begin
					if (wr.en) begin
						slot_idx_q <= wr.idx;
					end else if (word_s1 == 9'd0) begin
						slot_idx_q <= '0;
						pending_q  <= 1'b1;
					end
				end
				FUNC_TICK: begin
					if (countdown_q != 16'd0) begin
						countdown_q <= countdown_q - 16'd1;
					end
				end
				FUNC_READ: begin
					lost_q <= lost_next;
					if (pending_q) begin
						pending_q   <= 1'b0;
						countdown_q <= timeout_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the channel and skip the start code and the entry before it.
	assign chan_clamp = (chan_s1 > CHANNEL_MAX) ? CHANNEL_MAX : chan_s1;
	assign rd_base    = {1'b0, chan_clamp} + 10'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= fire_s1 && is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_read) begin
			lost_s2 <= lost_next;
		end
	end

	dmxsr_store #(
		.DEPTH (SLOT_STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (fire_s1 && is_read),
		.rd_idx  (rd_base),
		.level_a (level_a),
		.level_b (level_b),
		.level_c (level_c)
	);

	assign out_valid   = valid_s2;
	assign signal_lost = lost_s2;

endmodule

### hdl/dmxsr_store.sv
module dmxsr_store
	import dmxsr_pkg::*;
#(
	parameter int unsigned DEPTH = 516
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_req_t          wr,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [7:0]       level_a,
	output logic [7:0]       level_b,
	output logic [7:0]       level_c
);

	localparam int unsigned ROWS  = (DEPTH + 2) / 3;
	localparam int unsigned ROW_W = $clog2(ROWS);

	// highest index written since reset; everything above it reads as zero
	logic [IDX_W-1:0] fill_q;
	div3_t            wr_pos;
	div3_t            rd_pos;
	logic [7:0]       rdata_s2 [3];
	logic [2:0]       hit_s2;
	logic [1:0]       rem_s2;
	logic [7:0]       lvl [3];

	assign wr_pos = div3(wr.idx);
	assign rd_pos = div3(rd_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr.en && (wr.idx > fill_q)) begin
			fill_q <= wr.idx;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_bank
		logic [7:0]       mem [ROWS];
		logic [IDX_W-1:0] row_full;
		logic [ROW_W-1:0] rd_row;

		// bank k lands one row further when the base index sits past it
		assign row_full = rd_pos.quo + ((2'(k) < rd_pos.rem) ? 10'd1 : 10'd0);
		assign rd_row   = row_full[ROW_W-1:0];

		always_ff @(posedge clk) begin
			if (wr.en && (wr_pos.rem == 2'(k))) begin
				mem[wr_pos.quo[ROW_W-1:0]] <= wr.data;
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rdata_s2[k] <= mem[rd_row];
				hit_s2[k]   <= (rd_idx + IDX_W'(k)) <= fill_q;
			end
		end

		assign lvl[k] = hit_s2[k] ? rdata_s2[k] : 8'd0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rem_s2 <= rd_pos.rem;
		end
	end

	// hit_s2 is indexed by offset, data by bank: rotate data by the base bank
	always_comb begin
		level_a = 8'd0;
		level_b = 8'd0;
		level_c = 8'd0;
		unique case (rem_s2)
			2'd0: begin
				level_a = hit_s2[0] ? rdata_s2[0] : 8'd0;
				level_b = hit_s2[1] ? rdata_s2[1] : 8'd0;
				level_c = hit_s2[2] ? rdata_s2[2] : 8'd0;
			end
			2'd1: begin
				level_a = hit_s2[0] ? rdata_s2[1] : 8'd0;
				level_b = hit_s2[1] ? rdata_s2[2] : 8'd0;
				level_c = hit_s2[2] ? rdata_s2[0] : 8'd0;
			end
			2'd2: begin
				level_a = hit_s2[0] ? rdata_s2[2] : 8'd0;
				level_b = hit_s2[1] ? rdata_s2[0] : 8'd0;
				level_c = hit_s2[2] ? rdata_s2[1] : 8'd0;
			end
			default: begin
				level_a = lvl[0];
				level_b = lvl[1];
				level_c = lvl[2];
			end
		endcase
	end

endmodule
